[rtl/can_serial_command_parser_defines.svh]
`ifndef CAN_SERIAL_COMMAND_PARSER_DEFINES_SVH
`define CAN_SERIAL_COMMAND_PARSER_DEFINES_SVH
// Assertion helpers; they expect clk and rst_n in scope.
`define CSCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/cscp_pkg.sv]
`timescale 1ns / 1ps
package cscp_pkg;

    localparam logic [7:0] SOF_BYTE      = 8'hF1;
    localparam logic [7:0] BINARY_BYTE   = 8'hE7;
    localparam logic [7:0] KEEP_HI       = 8'hDE;
    localparam logic [7:0] KEEP_LO       = 8'hAD;
    localparam logic [7:0] DEVINFO_FLAGS = 8'h20;
    localparam logic [19:0] SPEED_LIMIT  = 20'd1000000;
    localparam int MAX_DATA_BYTES = 8;
    localparam int CHECKSUM_DEPTH = 9;

    localparam logic [7:0] CMD_BUILD_FRAME = 8'd0;
    localparam logic [7:0] CMD_TIME_SYNC   = 8'd1;
    localparam logic [7:0] CMD_DIG_IN      = 8'd2;
    localparam logic [7:0] CMD_ANA_IN      = 8'd3;
    localparam logic [7:0] CMD_DIG_OUT     = 8'd4;
    localparam logic [7:0] CMD_SETUP_BUS   = 8'd5;
    localparam logic [7:0] CMD_BUS_PARAMS  = 8'd6;
    localparam logic [7:0] CMD_DEV_INFO    = 8'd7;
    localparam logic [7:0] CMD_SW_MODE     = 8'd8;
    localparam logic [7:0] CMD_KEEPALIVE   = 8'd9;
    localparam logic [7:0] CMD_SYS_TYPE    = 8'd10;
    localparam logic [7:0] CMD_ECHO_FRAME  = 8'd11;
    localparam logic [7:0] CMD_NUM_BUSES   = 8'd12;
    localparam logic [7:0] CMD_GET_EXT     = 8'd13;
    localparam logic [7:0] CMD_SET_EXT     = 8'd14;

    localparam logic [2:0] EV_REPLY   = 3'd0;
    localparam logic [2:0] EV_CONSOLE = 3'd1;
    localparam logic [2:0] EV_SEND    = 3'd2;
    localparam logic [2:0] EV_ECHO    = 3'd3;
    localparam logic [2:0] EV_BUS0    = 3'd4;
    localparam logic [2:0] EV_BUS1    = 3'd5;
    localparam logic [2:0] EV_SYSTYPE = 3'd6;
    localparam logic [2:0] EV_BINARY  = 3'd7;

    localparam logic CFG_BUS_COUNT = 1'b0;
    localparam logic CFG_BUILD     = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD, PH_FRAME, PH_TSYNC, PH_DIGOUT, PH_SETUP,
        PH_SWMODE, PH_SYSTYPE, PH_ECHO, PH_EXTBUS
    } phase_t;

    typedef enum logic [3:0] {
        JOB_NONE, JOB_CONSOLE, JOB_BINMODE, JOB_TSYNC, JOB_DIGIN, JOB_ANAIN,
        JOB_BUSPARAM, JOB_DEVINFO, JOB_KEEPALIVE, JOB_NUMBUS, JOB_EXTGET,
        JOB_SEND, JOB_ECHO, JOB_BUS0, JOB_BUS1, JOB_SYSTYPE
    } job_t;

    // Parser state seen by the emitter; input bytes leave it unchanged while a job drains, configuration writes do not.
    typedef struct packed {
        logic [30:0] id;
        logic        ext;
        logic [1:0]  bus;
        logic [3:0]  len;
        logic [63:0] data;
        logic        b0_en;
        logic        b0_lis;
        logic [19:0] b0_sp;
        logic        b1_en;
        logic        b1_lis;
        logic [19:0] b1_sp;
        logic [7:0]  xor2;
        logic [7:0]  xor9;
        logic [1:0]  bus_count;
        logic [15:0] build;
    } snap_t;

    // Number of result beats a job produces.
    function automatic logic [4:0] job_beats(input job_t j);
        case (j)
            JOB_TSYNC:     job_beats = 5'd6;
            JOB_DIGIN:     job_beats = 5'd4;
            JOB_ANAIN:     job_beats = 5'd17;
            JOB_BUSPARAM:  job_beats = 5'd12;
            JOB_DEVINFO:   job_beats = 5'd8;
            JOB_KEEPALIVE: job_beats = 5'd4;
            JOB_NUMBUS:    job_beats = 5'd3;
            JOB_EXTGET:    job_beats = 5'd17;
            default:       job_beats = 5'd1;
        endcase
    endfunction

endpackage

[rtl/cscp_parser.sv]
`timescale 1ns / 1ps
module cscp_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           rx_byte,
    input  logic                 cfg_fire,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    output cscp_pkg::job_t       job,
    output cscp_pkg::snap_t      snap
);

    cscp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] id_reg, id_next;
    logic        ext_reg, ext_next;
    logic [1:0]  bus_reg, bus_next;
    logic [3:0]  len_reg, len_next;
    logic [7:0]  data_reg [cscp_pkg::MAX_DATA_BYTES], data_next [cscp_pkg::MAX_DATA_BYTES];
    logic [31:0] sw_reg, sw_next;
    logic [7:0]  cs_reg [cscp_pkg::CHECKSUM_DEPTH], cs_next [cscp_pkg::CHECKSUM_DEPTH];
    logic        b0_en_reg, b0_en_next, b0_lis_reg, b0_lis_next;
    logic        b1_en_reg, b1_en_next, b1_lis_reg, b1_lis_next;
    logic [19:0] b0_sp_reg, b0_sp_next, b1_sp_reg, b1_sp_next;
    logic [1:0]  bus_count_reg;
    logic [15:0] build_reg;

    logic [31:0] word;
    logic [19:0] clamped;
    logic [2:0]  s3;
    logic [7:0]  x9;

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        id_next     = id_reg;
        ext_next    = ext_reg;
        bus_next    = bus_reg;
        len_next    = len_reg;
        data_next   = data_reg;
        sw_next     = sw_reg;
        cs_next     = cs_reg;
        b0_en_next  = b0_en_reg;
        b0_lis_next = b0_lis_reg;
        b0_sp_next  = b0_sp_reg;
        b1_en_next  = b1_en_reg;
        b1_lis_next = b1_lis_reg;
        b1_sp_next  = b1_sp_reg;
        job         = cscp_pkg::JOB_NONE;
        s3          = step_reg[2:0];
        word        = 32'd0;
        case (s3[1:0])
            2'd0: word = {24'd0, rx_byte};
            2'd1: word = {sw_reg[31:16], rx_byte, sw_reg[7:0]};
            2'd2: word = {sw_reg[31:24], rx_byte, sw_reg[15:0]};
            default: word = {rx_byte, sw_reg[23:0]};
        endcase
        clamped = (word[19:0] > cscp_pkg::SPEED_LIMIT) ? cscp_pkg::SPEED_LIMIT : word[19:0];
        if (fire)
        begin
            unique case (phase_reg)
                cscp_pkg::PH_IDLE:
                begin
                    if (rx_byte == cscp_pkg::SOF_BYTE)
                        phase_next = cscp_pkg::PH_CMD;
                    else if (rx_byte == cscp_pkg::BINARY_BYTE)
                        job = cscp_pkg::JOB_BINMODE;
                    else
                        job = cscp_pkg::JOB_CONSOLE;
                end
                cscp_pkg::PH_CMD:
                begin
                    unique case (rx_byte)
                        cscp_pkg::CMD_BUILD_FRAME, cscp_pkg::CMD_SETUP_BUS,
                        cscp_pkg::CMD_SW_MODE, cscp_pkg::CMD_SYS_TYPE,
                        cscp_pkg::CMD_ECHO_FRAME, cscp_pkg::CMD_SET_EXT:
                        begin
                            step_next  = 5'd0;
                            cs_next[0] = cscp_pkg::SOF_BYTE;
                            unique case (rx_byte)
                                cscp_pkg::CMD_BUILD_FRAME: phase_next = cscp_pkg::PH_FRAME;
                                cscp_pkg::CMD_SETUP_BUS:   phase_next = cscp_pkg::PH_SETUP;
                                cscp_pkg::CMD_SW_MODE:     phase_next = cscp_pkg::PH_SWMODE;
                                cscp_pkg::CMD_SYS_TYPE:    phase_next = cscp_pkg::PH_SYSTYPE;
                                cscp_pkg::CMD_ECHO_FRAME:  phase_next = cscp_pkg::PH_ECHO;
                                default:                   phase_next = cscp_pkg::PH_EXTBUS;
                            endcase
                        end
                        cscp_pkg::CMD_TIME_SYNC:
                        begin
                            phase_next = cscp_pkg::PH_TSYNC;
                            step_next  = 5'd0;
                            job        = cscp_pkg::JOB_TSYNC;
                        end
                        cscp_pkg::CMD_DIG_IN:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_DIGIN;
                        end
                        cscp_pkg::CMD_ANA_IN:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_ANAIN;
                        end
                        cscp_pkg::CMD_DIG_OUT:
                        begin
                            phase_next = cscp_pkg::PH_DIGOUT;
                            cs_next[0] = cscp_pkg::SOF_BYTE;
                        end
                        cscp_pkg::CMD_BUS_PARAMS:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_BUSPARAM;
                        end
                        cscp_pkg::CMD_DEV_INFO:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_DEVINFO;
                        end
                        cscp_pkg::CMD_KEEPALIVE:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_KEEPALIVE;
                        end
                        cscp_pkg::CMD_NUM_BUSES:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            job        = cscp_pkg::JOB_NUMBUS;
                        end
                        cscp_pkg::CMD_GET_EXT:
                        begin
                            phase_next = cscp_pkg::PH_IDLE;
                            step_next  = 5'd0;
                            job        = cscp_pkg::JOB_EXTGET;
                        end
                        default:
                        begin
                            // Unknown code: keep waiting for a command.
                        end
                    endcase
                end
                cscp_pkg::PH_FRAME, cscp_pkg::PH_ECHO:
                begin
                    step_next = step_reg + 5'd1;
                    if (step_reg < 5'd8)
                        cs_next[4'(step_reg + 5'd1)] = rx_byte;
                    if (step_reg < 5'd4)
                    begin
                        case (step_reg[1:0])
                            2'd0: id_next = {24'd0, rx_byte};
                            2'd1: id_next = {id_reg[31:16], rx_byte, id_reg[7:0]};
                            2'd2: id_next = {id_reg[31:24], rx_byte, id_reg[15:0]};
                            default:
                            begin
                                id_next  = {1'b0, rx_byte[6:0], id_reg[23:0]};
                                ext_next = rx_byte[7];
                            end
                        endcase
                    end
                    else if (step_reg == 5'd4)
                        bus_next = (phase_reg == cscp_pkg::PH_ECHO) ? {1'b0, rx_byte[0]}
                                                                    : rx_byte[1:0];
                    else if (step_reg == 5'd5)
                        len_next = (rx_byte[3:0] > 4'd8) ? 4'd8 : rx_byte[3:0];
                    else if ({1'b0, step_reg} < 6'd6 + {2'b00, len_reg})
                        data_next[3'(step_reg - 5'd6)] = rx_byte;
                    else
                    begin
                        phase_next = cscp_pkg::PH_IDLE;
                        job = (phase_reg == cscp_pkg::PH_ECHO) ? cscp_pkg::JOB_ECHO
                                                               : cscp_pkg::JOB_SEND;
                    end
                end
                cscp_pkg::PH_SETUP:
                begin
                    sw_next   = word;
                    step_next = step_reg + 5'd1;
                    if (s3 == 3'd3)
                    begin
                        if (word != 32'd0)
                        begin
                            if (word[31])
                            begin
                                b0_en_next  = word[30];
                                b0_lis_next = word[29];
                            end
                            else
                                b0_en_next = 1'b1;
                            b0_sp_next = clamped;
                        end
                        else
                            b0_en_next = 1'b0;
                        job = cscp_pkg::JOB_BUS0;
                    end
                    else if (s3 == 3'd7)
                    begin
                        if (word != 32'd0 && bus_count_reg > 2'd1)
                        begin
                            if (word[31])
                            begin
                                b1_en_next  = word[30];
                                b1_lis_next = word[29];
                            end
                            else
                                b1_en_next = 1'b1;
                            b1_sp_next = clamped;
                        end
                        else
                            b1_en_next = 1'b0;
                        job = cscp_pkg::JOB_BUS1;
                        phase_next = cscp_pkg::PH_IDLE;
                    end
                end
                cscp_pkg::PH_SYSTYPE:
                begin
                    job = cscp_pkg::JOB_SYSTYPE;
                    phase_next = cscp_pkg::PH_IDLE;
                end
                cscp_pkg::PH_EXTBUS:
                begin
                    if (step_reg < 5'd11)
                        sw_next = {24'd0, rx_byte};
                    else if (step_reg == 5'd11)
                    begin
                        sw_next = {rx_byte, sw_reg[23:0]};
                        phase_next = cscp_pkg::PH_IDLE;
                    end
                    step_next = step_reg + 5'd1;
                end
                default: phase_next = cscp_pkg::PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cscp_pkg::PH_IDLE;
            step_reg      <= 5'd0;
            id_reg        <= 32'd0;
            ext_reg       <= 1'b0;
            bus_reg       <= 2'd0;
            len_reg       <= 4'd0;
            sw_reg        <= 32'd0;
            b0_en_reg     <= 1'b0;
            b0_lis_reg    <= 1'b0;
            b0_sp_reg     <= 20'd0;
            b1_en_reg     <= 1'b0;
            b1_lis_reg    <= 1'b0;
            b1_sp_reg     <= 20'd0;
            bus_count_reg <= 2'd2;
            build_reg     <= 16'd0;
            for (int i = 0; i < cscp_pkg::MAX_DATA_BYTES; i++)
                data_reg[i] <= 8'd0;
            for (int i = 0; i < cscp_pkg::CHECKSUM_DEPTH; i++)
                cs_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            step_reg   <= step_next;
            id_reg     <= id_next;
            ext_reg    <= ext_next;
            bus_reg    <= bus_next;
            len_reg    <= len_next;
            sw_reg     <= sw_next;
            b0_en_reg  <= b0_en_next;
            b0_lis_reg <= b0_lis_next;
            b0_sp_reg  <= b0_sp_next;
            b1_en_reg  <= b1_en_next;
            b1_lis_reg <= b1_lis_next;
            b1_sp_reg  <= b1_sp_next;
            data_reg   <= data_next;
            cs_reg     <= cs_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    cscp_pkg::CFG_BUS_COUNT: bus_count_reg <= cfg_data[1:0];
                    default:                 build_reg     <= cfg_data;
                endcase
            end
        end
    end

    always_comb
    begin
        x9 = 8'd0;
        for (int i = 0; i < cscp_pkg::CHECKSUM_DEPTH; i++)
            x9 = x9 ^ cs_reg[i];
        snap.id        = id_reg[30:0];
        snap.ext       = ext_reg;
        snap.bus       = bus_reg;
        snap.len       = len_reg;
        for (int i = 0; i < cscp_pkg::MAX_DATA_BYTES; i++)
            snap.data[8*i +: 8] = ({1'b0, 4'(i)} < {1'b0, len_reg}) ? data_reg[i] : 8'd0;
        snap.b0_en     = b0_en_reg;
        snap.b0_lis    = b0_lis_reg;
        snap.b0_sp     = b0_sp_reg;
        snap.b1_en     = b1_en_reg;
        snap.b1_lis    = b1_lis_reg;
        snap.b1_sp     = b1_sp_reg;
        snap.xor2      = cs_reg[0] ^ cs_reg[1];
        snap.xor9      = x9;
        snap.bus_count = bus_count_reg;
        snap.build     = build_reg;
    end

endmodule

[rtl/cscp_emitter.sv]
`timescale 1ns / 1ps
module cscp_emitter
(
    input  logic             clk,
    input  logic             rst_n,
    input  cscp_pkg::job_t   job,
    input  logic             load,
    input  logic [7:0]       job_byte,
    input  logic [31:0]      job_now,
    input  cscp_pkg::snap_t  snap,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_kind,
    output logic [135:0]     out_data,
    output logic             out_last
);

    cscp_pkg::job_t job_reg;
    logic        busy_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  byte_reg;
    logic [31:0] now_reg;
    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [135:0] data_reg;
    logic        last_reg;

    logic        adv, is_last;
    logic [2:0]  kind;
    logic [7:0]  val;
    logic [135:0] beat;

    assign adv     = busy_reg && (!valid_reg || out_ready);
    assign is_last = (idx_reg == cscp_pkg::job_beats(job_reg) - 5'd1);
    assign free    = !busy_reg || (adv && is_last);

    always_comb
    begin
        kind = cscp_pkg::EV_REPLY;
        val  = 8'd0;
        case (idx_reg)
            5'd0: val = cscp_pkg::SOF_BYTE;
            default: val = 8'd0;
        endcase
        case (job_reg)
            cscp_pkg::JOB_CONSOLE: begin kind = cscp_pkg::EV_CONSOLE; val = byte_reg; end
            cscp_pkg::JOB_BINMODE: begin kind = cscp_pkg::EV_BINARY; val = 8'd0; end
            cscp_pkg::JOB_SYSTYPE: begin kind = cscp_pkg::EV_SYSTYPE; val = byte_reg; end
            cscp_pkg::JOB_SEND:    begin kind = cscp_pkg::EV_SEND; val = 8'd0; end
            cscp_pkg::JOB_ECHO:    begin kind = cscp_pkg::EV_ECHO; val = 8'd0; end
            cscp_pkg::JOB_BUS0:    begin kind = cscp_pkg::EV_BUS0; val = 8'd0; end
            cscp_pkg::JOB_BUS1:    begin kind = cscp_pkg::EV_BUS1; val = 8'd0; end
            cscp_pkg::JOB_TSYNC:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_TIME_SYNC;
                    5'd2: val = now_reg[7:0];
                    5'd3: val = now_reg[15:8];
                    5'd4: val = now_reg[23:16];
                    default: val = now_reg[31:24];
                endcase
            cscp_pkg::JOB_DIGIN:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_DIG_IN;
                    5'd3: val = snap.xor2;
                    default: val = 8'd0;
                endcase
            cscp_pkg::JOB_ANAIN:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_ANA_IN;
                    5'd16: val = snap.xor9;
                    default: val = 8'd0;
                endcase
            cscp_pkg::JOB_BUSPARAM:
                // Bus 0 status and speed, then a zero bus 1 status and bus 1 speed.
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_BUS_PARAMS;
                    5'd2: val = {3'd0, snap.b0_lis, 3'd0, snap.b0_en};
                    5'd3: val = snap.b0_sp[7:0];
                    5'd4: val = snap.b0_sp[15:8];
                    5'd5: val = {4'd0, snap.b0_sp[19:16]};
                    5'd8: val = snap.b1_sp[7:0];
                    5'd9: val = snap.b1_sp[15:8];
                    5'd10: val = {4'd0, snap.b1_sp[19:16]};
                    default: val = 8'd0;
                endcase
            cscp_pkg::JOB_DEVINFO:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_DEV_INFO;
                    5'd2: val = snap.build[7:0];
                    5'd3: val = snap.build[15:8];
                    5'd4: val = cscp_pkg::DEVINFO_FLAGS;
                    default: val = 8'd0;
                endcase
            cscp_pkg::JOB_KEEPALIVE:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_KEEPALIVE;
                    5'd2: val = cscp_pkg::KEEP_HI;
                    default: val = cscp_pkg::KEEP_LO;
                endcase
            cscp_pkg::JOB_NUMBUS:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_NUM_BUSES;
                    default: val = {6'd0, snap.bus_count};
                endcase
            cscp_pkg::JOB_EXTGET:
                case (idx_reg)
                    5'd0: val = cscp_pkg::SOF_BYTE;
                    5'd1: val = cscp_pkg::CMD_GET_EXT;
                    default: val = 8'd0;
                endcase
            default: val = 8'd0;
        endcase

        beat = 136'd0;
        beat[7:0] = val;
        if (kind == cscp_pkg::EV_SEND || kind == cscp_pkg::EV_ECHO)
        begin
            beat[38:8]   = snap.id;
            beat[39]     = snap.ext;
            beat[41:40]  = (kind == cscp_pkg::EV_SEND) ? snap.bus : 2'd0;
            beat[45:42]  = snap.len;
            beat[109:46] = snap.data;
        end
        else if (kind == cscp_pkg::EV_BUS0)
        begin
            beat[110]     = snap.b0_en;
            beat[111]     = snap.b0_lis;
            beat[131:112] = snap.b0_sp;
        end
        else if (kind == cscp_pkg::EV_BUS1)
        begin
            beat[110]     = snap.b1_en;
            beat[111]     = snap.b1_lis;
            beat[131:112] = snap.b1_sp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= 5'd0;
            valid_reg <= 1'b0;
            job_reg   <= cscp_pkg::JOB_NONE;
        end
        else
        begin
            if (adv)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
            // A new job can only arrive when the current one is done or on its last beat.
            if (load)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 5'd0;
                job_reg  <= job;
            end
            else if (adv)
            begin
                idx_reg <= is_last ? 5'd0 : idx_reg + 5'd1;
                if (is_last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= job_byte;
            now_reg  <= job_now;
        end
        if (adv)
        begin
            kind_reg <= kind;
            data_reg <= beat;
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

[rtl/can_serial_command_parser.sv]
`timescale 1ns / 1ps
// Host-link command parser for a CAN bridge. Each byte taken on the s_axis
// channel is parsed in the cycle it is accepted; the parser state (phase,
// frame under assembly, checksum buffer, bus settings) is updated at that
// edge and any results are handed to an emitter as one job. The emitter
// sends one result per cycle on the m_axis channel, unless m_axis_tready stalls
// it, through a registered output stage. After a byte that causes no result the
// next byte can follow at once, and after one that causes one result too, unless
// the output stalls. A query reply of N bytes (up to 17 for the analog-input and
// extended-bus replies) holds off the input until its last beat enters the
// output stage. tlast marks the last result caused by one input byte.
// Configuration writes are taken in any cycle and should only be made while idle.
module can_serial_command_parser
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // rx_byte[7:0], now_us[39:8]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // byte_value[7:0], frame_id[38:8], frame_extended[39], frame_bus[41:40],
    // frame_length[45:42], frame_data[109:46], bus_enabled[110],
    // bus_listen_only[111], bus_speed[131:112], zero fill above
    output logic [135:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // event_kind[2:0]
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,      // 0 bus_count, 1 build_number
    input  logic [15:0]  cfg_data
);

    logic            in_fire;
    logic            free;
    cscp_pkg::job_t  job;
    cscp_pkg::snap_t snap;

    // A transaction is taken whenever the emitter can accept the job it may cause.
    assign s_axis_tready = free;
    assign in_fire       = s_axis_tvalid && free;
    assign cfg_ready     = 1'b1;

    cscp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .rx_byte   (s_axis_tdata[7:0]),
        .cfg_fire  (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (job),
        .snap      (snap)
    );

    cscp_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .load      (in_fire && (job != cscp_pkg::JOB_NONE)),
        .job_byte  (s_axis_tdata[7:0]),
        .job_now   (s_axis_tdata[39:8]),
        .snap      (snap),
        .free      (free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

[rtl/cscp_checker.sv]
`timescale 1ns / 1ps
`include "can_serial_command_parser_defines.svh"
module cscp_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    logic out_stall;
    logic bus_result;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign bus_result = m_axis_tvalid
                        && (m_axis_tuser == cscp_pkg::EV_BUS0 || m_axis_tuser == cscp_pkg::EV_BUS1);

    // A stalled result stays offered unchanged.
    `CSCP_ASSERT_NEXT(a_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // Every event other than a reply byte stands alone for its input byte.
    `CSCP_ASSERT_NOW(a_single, m_axis_tvalid && m_axis_tuser != cscp_pkg::EV_REPLY, m_axis_tlast)
    // Bus speeds never exceed the clamp.
    `CSCP_ASSERT_NOW(a_speed, bus_result, m_axis_tdata[131:112] <= cscp_pkg::SPEED_LIMIT)

endmodule

bind can_serial_command_parser cscp_checker u_cscp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
